// ===== rtl/bpw_pkg.sv =====
package bpw_pkg;

  // fraction bits of the weight and smoothing formats
  localparam int FRAC_BITS = 30;

  // 1.0 in unsigned q1.30
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_COINCIDENT = 2'd1;
  localparam logic [1:0] ST_RANGE      = 2'd2;

endpackage

// ===== rtl/becke_partition_weight.sv =====
// Becke partition weight unit. Load items (opcode 0) write one atom center into the
// center table and return weight 0, status 0; out_valid is set from the S_DONE state,
// which follows the input transfer. A query item (opcode 1) returns the Becke weight
// of atom atom_index at the query point in unsigned q1.30, or status 2 for an index at
// or beyond atom_count, or status 1 when two centers in use coincide. The block takes
// one item at a time and holds in_stall high while it works. A query runs the
// coincidence scan, the point distances, the cell products and the final division in
// order, using the one shared 32x32 multiplier, the 32-step square root unit and the
// 30-step divider, which every atom pair passes through in turn. atom_count is written
// through the cfg port, always ready; the user must write it only while the block is
// idle, and the block itself does not enforce this.
module becke_partition_weight #(
  parameter int MAX_ATOMS     = 16,
  parameter int SMOOTH_PASSES = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [3:0]         in_atom_index,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [30:0]        out_weight,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_atom_count
);

  localparam int AW = $clog2(MAX_ATOMS);
  localparam int NW = $clog2(MAX_ATOMS + 1);
  localparam int CW = (NW > 5) ? NW : 5;
  localparam int SW = 31 + $clog2(MAX_ATOMS);
  localparam int PW = (SMOOTH_PASSES > 1) ? $clog2(SMOOTH_PASSES) : 1;

  typedef enum logic [26:0] {
    S_IDLE    = 27'h0000001,
    S_CHK_A   = 27'h0000002,
    S_CHK_B   = 27'h0000004,
    S_CHK_C   = 27'h0000008,
    S_DQ_RD   = 27'h0000010,
    S_DQ_LD   = 27'h0000020,
    S_DS_MUL  = 27'h0000040,
    S_DS_ACC  = 27'h0000080,
    S_DS_SQ   = 27'h0000100,
    S_DS_WAIT = 27'h0000200,
    S_DQ_WR   = 27'h0000400,
    S_PK_INIT = 27'h0000800,
    S_PJ_SEL  = 27'h0001000,
    S_PJ_RDK  = 27'h0002000,
    S_PJ_RDJ  = 27'h0004000,
    S_PJ_LD   = 27'h0008000,
    S_PR_DIV  = 27'h0010000,
    S_PR_WAIT = 27'h0020000,
    S_SM_M2   = 27'h0040000,
    S_SM_M3   = 27'h0080000,
    S_SM_UPD  = 27'h0100000,
    S_P_MUL   = 27'h0200000,
    S_P_UPD   = 27'h0400000,
    S_PK_END  = 27'h0800000,
    S_W_CHK   = 27'h1000000,
    S_W_WAIT  = 27'h2000000,
    S_DONE    = 27'h4000000
  } state_t;

  // control registers
  state_t        state_r, state_nxt;
  logic [4:0]    atom_count_r;
  logic          out_valid_r, out_valid_nxt;

  // datapath registers
  logic [3:0]    idx_r, idx_nxt;
  logic [95:0]   qpt_r, qpt_nxt;
  logic [NW-1:0] a_r, a_nxt;
  logic [NW-1:0] b_r, b_nxt;
  logic [95:0]   ca_r, ca_nxt;
  logic [95:0]   opa_r, opa_nxt;
  logic [95:0]   opb_r, opb_nxt;
  logic [1:0]    axis_r, axis_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic          ret_r, ret_nxt;
  logic [31:0]   dk_r, dk_nxt;
  logic [31:0]   dj_r, dj_nxt;
  logic          neg_r, neg_nxt;
  logic [30:0]   m_r, m_nxt;
  logic [PW-1:0] pass_r, pass_nxt;
  logic [30:0]   p_r, p_nxt;
  logic [30:0]   pi_r, pi_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [30:0]   wres_r, wres_nxt;
  logic [1:0]    wst_r, wst_nxt;
  logic [30:0]   out_weight_r, out_weight_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [63:0]   prod_r;

  // shared unit hookups
  logic [31:0]   mul_a, mul_b;
  logic          sq_start, sq_done;
  logic [31:0]   sq_root;
  logic          div_start, div_done;
  logic [SW-1:0] div_num, div_den;
  logic [30:0]   div_quo;

  // memory hookups
  logic          cen_we;
  logic [AW-1:0] cen_raddr;
  logic [95:0]   cen_rdata;
  logic          d_we;
  logic [AW-1:0] d_raddr;
  logic [31:0]   d_rdata;

  // derived values
  logic [CW-1:0] cnt_ext;
  logic [NW-1:0] n_cnt;
  logic          idx_out;
  logic          slot_ok;
  logic [31:0]   ax_a, ax_b;
  logic [32:0]   diff;
  logic [32:0]   diff_abs;
  logic [31:0]   mag_dd;
  logic [32:0]   tri_m;
  logic [32:0]   tri_sub;
  logic [31:0]   s_up, s_dn;
  logic [30:0]   s_fac;

  // atoms in use, clamped to the table
  assign cnt_ext = CW'(atom_count_r);
  assign n_cnt   = (cnt_ext > CW'(MAX_ATOMS)) ? NW'(MAX_ATOMS) : NW'(cnt_ext);
  assign idx_out = CW'(in_atom_index) >= CW'(n_cnt);
  assign slot_ok = CW'(in_atom_index) < CW'(MAX_ATOMS);

  // per-axis difference magnitude for the squared distance
  always_comb begin
    case (axis_r)
      2'd0: begin
        ax_a = opa_r[95:64];
        ax_b = opb_r[95:64];
      end
      2'd1: begin
        ax_a = opa_r[63:32];
        ax_b = opb_r[63:32];
      end
      default: begin
        ax_a = opa_r[31:0];
        ax_b = opb_r[31:0];
      end
    endcase
  end
  assign diff     = {ax_a[31], ax_a} - {ax_b[31], ax_b};
  assign diff_abs = diff[32] ? (~diff + 33'd1) : diff;

  // distance difference magnitude for mu
  assign mag_dd = (dk_r >= dj_r) ? dk_r - dj_r : dj_r - dk_r;

  // smoothing update 3m - m^3, and step factor
  assign tri_m   = ({2'b00, m_r} << 1) + {2'b00, m_r};
  assign tri_sub = tri_m - {1'b0, prod_r[61:30]};
  assign s_up    = {1'b0, bpw_pkg::Q30_ONE} + {1'b0, m_r};
  assign s_dn    = {1'b0, bpw_pkg::Q30_ONE} - {1'b0, m_r};
  assign s_fac   = neg_r ? s_up[31:1] : s_dn[31:1];

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    idx_nxt        = idx_r;
    qpt_nxt        = qpt_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    ca_nxt         = ca_r;
    opa_nxt        = opa_r;
    opb_nxt        = opb_r;
    axis_nxt       = axis_r;
    acc_nxt        = acc_r;
    ret_nxt        = ret_r;
    dk_nxt         = dk_r;
    dj_nxt         = dj_r;
    neg_nxt        = neg_r;
    m_nxt          = m_r;
    pass_nxt       = pass_r;
    p_nxt          = p_r;
    pi_nxt         = pi_r;
    sum_nxt        = sum_r;
    wres_nxt       = wres_r;
    wst_nxt        = wst_r;
    out_weight_nxt = out_weight_r;
    out_status_nxt = out_status_r;
    cen_we         = 1'b0;
    cen_raddr      = a_r[AW-1:0];
    d_we           = 1'b0;
    d_raddr        = a_r[AW-1:0];
    mul_a          = 32'd0;
    mul_b          = 32'd0;
    sq_start       = 1'b0;
    div_start      = 1'b0;
    div_num        = SW'(mag_dd);
    div_den        = SW'(sq_root);

    // result transfer frees the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt  = in_atom_index;
          qpt_nxt  = {in_point_x, in_point_y, in_point_z};
          wres_nxt = 31'd0;
          wst_nxt  = bpw_pkg::ST_OK;
          sum_nxt  = '0;
          pi_nxt   = 31'd0;
          a_nxt    = '0;
          b_nxt    = NW'(1);
          if (in_opcode == bpw_pkg::OP_LOAD) begin
            cen_we    = slot_ok;
            state_nxt = S_DONE;
          end else if (idx_out) begin
            wst_nxt   = bpw_pkg::ST_RANGE;
            state_nxt = S_DONE;
          end else if (n_cnt >= NW'(2)) begin
            state_nxt = S_CHK_A;
          end else begin
            state_nxt = S_DQ_RD;
          end
        end
      end
      // scan every center pair for identical coordinates
      S_CHK_A: begin
        cen_raddr = a_r[AW-1:0];
        state_nxt = S_CHK_B;
      end
      S_CHK_B: begin
        ca_nxt    = cen_rdata;
        cen_raddr = b_r[AW-1:0];
        state_nxt = S_CHK_C;
      end
      S_CHK_C: begin
        if (cen_rdata == ca_r) begin
          wst_nxt   = bpw_pkg::ST_COINCIDENT;
          state_nxt = S_DONE;
        end else if (b_r + NW'(1) < n_cnt) begin
          b_nxt     = b_r + NW'(1);
          state_nxt = S_CHK_A;
        end else if (a_r + NW'(2) < n_cnt) begin
          a_nxt     = a_r + NW'(1);
          b_nxt     = a_r + NW'(2);
          state_nxt = S_CHK_A;
        end else begin
          a_nxt     = '0;
          state_nxt = S_DQ_RD;
        end
      end
      // distance from the query point to each center
      S_DQ_RD: begin
        cen_raddr = a_r[AW-1:0];
        state_nxt = S_DQ_LD;
      end
      S_DQ_LD: begin
        opa_nxt   = qpt_r;
        opb_nxt   = cen_rdata;
        acc_nxt   = 64'd0;
        axis_nxt  = 2'd0;
        ret_nxt   = 1'b0;
        state_nxt = S_DS_MUL;
      end
      // distance routine: three squares, then square root
      S_DS_MUL: begin
        mul_a     = diff_abs[31:0];
        mul_b     = diff_abs[31:0];
        state_nxt = S_DS_ACC;
      end
      S_DS_ACC: begin
        acc_nxt = acc_r + 64'((65'(prod_r) + 65'd3) >> 2);
        if (axis_r == 2'd2) begin
          state_nxt = S_DS_SQ;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_DS_MUL;
        end
      end
      S_DS_SQ: begin
        sq_start  = 1'b1;
        state_nxt = S_DS_WAIT;
      end
      S_DS_WAIT: begin
        if (sq_done) begin
          state_nxt = ret_r ? S_PR_DIV : S_DQ_WR;
        end
      end
      S_DQ_WR: begin
        d_we = 1'b1;
        if (a_r + NW'(1) < n_cnt) begin
          a_nxt     = a_r + NW'(1);
          state_nxt = S_DQ_RD;
        end else begin
          a_nxt     = '0;
          state_nxt = S_PK_INIT;
        end
      end
      // cell product of atom a over every other atom b
      S_PK_INIT: begin
        p_nxt     = bpw_pkg::Q30_ONE;
        b_nxt     = '0;
        state_nxt = S_PJ_SEL;
      end
      S_PJ_SEL: begin
        if (b_r == n_cnt) begin
          state_nxt = S_PK_END;
        end else if (b_r == a_r) begin
          b_nxt = b_r + NW'(1);
        end else begin
          state_nxt = S_PJ_RDK;
        end
      end
      S_PJ_RDK: begin
        cen_raddr = a_r[AW-1:0];
        d_raddr   = a_r[AW-1:0];
        state_nxt = S_PJ_RDJ;
      end
      S_PJ_RDJ: begin
        opa_nxt   = cen_rdata;
        dk_nxt    = d_rdata;
        cen_raddr = b_r[AW-1:0];
        d_raddr   = b_r[AW-1:0];
        state_nxt = S_PJ_LD;
      end
      S_PJ_LD: begin
        opb_nxt   = cen_rdata;
        dj_nxt    = d_rdata;
        acc_nxt   = 64'd0;
        axis_nxt  = 2'd0;
        ret_nxt   = 1'b1;
        state_nxt = S_DS_MUL;
      end
      // mu = |dk - dj| / r, saturated at one
      S_PR_DIV: begin
        div_start = 1'b1;
        neg_nxt   = dk_r < dj_r;
        state_nxt = S_PR_WAIT;
      end
      S_PR_WAIT: begin
        if (div_done) begin
          m_nxt     = div_quo;
          pass_nxt  = '0;
          state_nxt = S_SM_M2;
        end
      end
      // smoothing passes on the magnitude
      S_SM_M2: begin
        mul_a     = {1'b0, m_r};
        mul_b     = {1'b0, m_r};
        state_nxt = S_SM_M3;
      end
      S_SM_M3: begin
        mul_a     = prod_r[61:30];
        mul_b     = {1'b0, m_r};
        state_nxt = S_SM_UPD;
      end
      S_SM_UPD: begin
        m_nxt = tri_sub[31:1];
        if (pass_r == PW'(SMOOTH_PASSES - 1)) begin
          state_nxt = S_P_MUL;
        end else begin
          pass_nxt  = pass_r + PW'(1);
          state_nxt = S_SM_M2;
        end
      end
      S_P_MUL: begin
        mul_a     = {1'b0, p_r};
        mul_b     = {1'b0, s_fac};
        state_nxt = S_P_UPD;
      end
      S_P_UPD: begin
        p_nxt     = prod_r[60:30];
        b_nxt     = b_r + NW'(1);
        state_nxt = S_PJ_SEL;
      end
      S_PK_END: begin
        sum_nxt = sum_r + SW'(p_r);
        if (CW'(a_r) == CW'(idx_r)) begin
          pi_nxt = p_r;
        end
        if (a_r + NW'(1) < n_cnt) begin
          a_nxt     = a_r + NW'(1);
          state_nxt = S_PK_INIT;
        end else begin
          state_nxt = S_W_CHK;
        end
      end
      // normalize the product of the asked atom
      S_W_CHK: begin
        if (pi_r == 31'd0) begin
          wres_nxt  = 31'd0;
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = SW'(pi_r);
          div_den   = sum_r;
          state_nxt = S_W_WAIT;
        end
      end
      S_W_WAIT: begin
        if (div_done) begin
          wres_nxt  = div_quo;
          state_nxt = S_DONE;
        end
      end
      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_weight_nxt = wres_r;
          out_status_nxt = wst_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      atom_count_r <= 5'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        atom_count_r <= cfg_atom_count;
      end
    end
  end

  // datapath state
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    qpt_r        <= qpt_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    ca_r         <= ca_nxt;
    opa_r        <= opa_nxt;
    opb_r        <= opb_nxt;
    axis_r       <= axis_nxt;
    acc_r        <= acc_nxt;
    ret_r        <= ret_nxt;
    dk_r         <= dk_nxt;
    dj_r         <= dj_nxt;
    neg_r        <= neg_nxt;
    m_r          <= m_nxt;
    pass_r       <= pass_nxt;
    p_r          <= p_nxt;
    pi_r         <= pi_nxt;
    sum_r        <= sum_nxt;
    wres_r       <= wres_nxt;
    wst_r        <= wst_nxt;
    out_weight_r <= out_weight_nxt;
    out_status_r <= out_status_nxt;
    prod_r       <= mul_a * mul_b;
  end

  // center table, x y z packed in one word
  bpw_ram #(
    .WIDTH(96),
    .DEPTH(MAX_ATOMS)
  ) u_cen_ram (
    .clk   (clk),
    .we    (cen_we),
    .waddr (AW'(in_atom_index)),
    .wdata ({in_point_x, in_point_y, in_point_z}),
    .raddr (cen_raddr),
    .rdata (cen_rdata)
  );

  // query point distance to each center
  bpw_ram #(
    .WIDTH(32),
    .DEPTH(MAX_ATOMS)
  ) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (a_r[AW-1:0]),
    .wdata (sq_root),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  bpw_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (acc_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  bpw_div #(
    .SW(SW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_weight = out_weight_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  // flagged results carry no weight
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != bpw_pkg::ST_OK |-> out_weight_r == 31'd0)
    else $error("flagged result with nonzero weight");

  // a weight never exceeds one
  a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_weight_r <= bpw_pkg::Q30_ONE)
    else $error("weight above one");

  // divider finishes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_PR_WAIT || state_r == S_W_WAIT)
    else $error("divider result not awaited");
`endif

endmodule

// ===== rtl/bpw_ram.sv =====
module bpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bpw_isqrt.sv =====
module bpw_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r;
  logic        done_r;
  logic [63:0] v_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == 64'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // one result bit per cycle, bit walks down by two places
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      res_r <= 64'd0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

// ===== rtl/bpw_div.sv =====
module bpw_div #(
  parameter int SW = 35
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [SW-1:0] num,
  input  logic [SW-1:0] den,
  output logic          done,
  output logic [30:0]   quo
);

  logic          busy_r;
  logic          done_r;
  logic [4:0]    cnt_r;
  logic          top_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] den_r;
  logic [29:0]   q_r;
  logic [SW:0]   rem2;
  logic          ge;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, den_r};

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(bpw_pkg::FRAC_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, integer bit first then one fraction bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      top_r <= num >= den;
      rem_r <= (num >= den) ? num - den : num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? SW'(rem2 - {1'b0, den_r}) : rem2[SW-1:0];
      q_r   <= {q_r[28:0], ge};
    end
  end

  // quotient saturates at 1.0
  assign quo  = top_r ? bpw_pkg::Q30_ONE : {1'b0, q_r};
  assign done = done_r;

endmodule
